// ===== rtl/core/u2f_pkg.sv =====
// u2f_pkg: shared types, constants and the fibonacci term table for the
// utf-8 to fibonacci-code transcoder; no dependencies
package u2f_pkg;

  localparam int FIB_TERMS  = 29;
  localparam int CP_W       = 21;
  localparam int TASK_DEPTH = 2;
  localparam int OUT_DEPTH  = 2;
  localparam int ZSTEPS     = 4;

  localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

  localparam logic [7:0] ASCII_LO = 8'h00;
  localparam logic [7:0] ASCII_HI = 8'h7F;
  localparam logic [7:0] CONT_LO  = 8'h80;
  localparam logic [7:0] CONT_HI  = 8'hBF;
  localparam logic [7:0] LEAD2_LO = 8'hC0;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF7;
  localparam logic [1:0] CONT_TAG = 2'b10;

  localparam logic [1:0] CLS_1B = 2'd0;
  localparam logic [1:0] CLS_2B = 2'd1;
  localparam logic [1:0] CLS_3B = 2'd2;
  localparam logic [1:0] CLS_4B = 2'd3;

  function automatic longint fib_val(int n);
    longint a;
    longint b;
    longint t;
    a = 1;
    b = 2;
    for (int k = 0; k < n; k++) begin
      t = a + b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  localparam int FIB_W  = $clog2(fib_val(FIB_TERMS - 1) + 1);
  localparam int VW     = (FIB_W > CP_W) ? FIB_W : CP_W;
  localparam int IDX_W  = $clog2(FIB_TERMS);
  localparam int CODE_W = FIB_TERMS + 1;
  localparam int LEN_W  = $clog2(CODE_W + 1);

  typedef logic [FIB_W-1:0] fib_tab_t [FIB_TERMS];
  typedef logic signed [IDX_W:0] idx_t;

  function automatic fib_tab_t fib_build();
    fib_tab_t t;
    for (int k = 0; k < FIB_TERMS; k++) begin
      t[k] = FIB_W'(fib_val(k));
    end
    return t;
  endfunction

  localparam fib_tab_t FIB_TAB = fib_build();

  // highest term not above the largest value a sequence length can give
  function automatic int fib_start(longint maxv);
    int r;
    r = 0;
    for (int k = 0; k < FIB_TERMS; k++) begin
      if (fib_val(k) <= maxv) r = k;
    end
    return r;
  endfunction

  localparam int START1 = fib_start(128);
  localparam int START2 = fib_start(2048);
  localparam int START3 = fib_start(65536);
  localparam int START4 = fib_start(longint'(CP_MAX) + 1);

  function automatic idx_t start_idx(logic [1:0] cls);
    idx_t r;
    unique case (cls)
      CLS_1B:  r = idx_t'(START1);
      CLS_2B:  r = idx_t'(START2);
      CLS_3B:  r = idx_t'(START3);
      CLS_4B:  r = idx_t'(START4);
      default: r = idx_t'(START4);
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic            err;
    logic            last;
    logic [1:0]      cls;
    logic [CP_W-1:0] cp;
  } job_t;

  typedef struct packed {
    logic              err;
    logic              last;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } hand_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } res_t;

endpackage

// ===== rtl/core/utf8_to_fibonacci_transcoder_top.sv =====
// utf8_to_fibonacci_transcoder_top: utf-8 decoder front, job queue, zeckendorf
// search, byte packer and result queue; depends on u2f_pkg and all u2f modules
//
//   channel  direction  handshake         request fields
//   input    in         push / full       in_byte, in_last
//   result   out        empty / pop       out_byte, out_last, out_error
//
// the front takes one byte per cycle while the job queue has room
// the search tests four fibonacci terms at a time, from the top term that the sequence
// length allows, and hands each finished codeword to the packer, which packs it into bytes
// search and packing overlap, so the next code point is searched while the last is packed
// reset is synchronous, active low, and empties every queue
// a stalled result queue backs up through the packer and search to full
module utf8_to_fibonacci_transcoder_top #(
  parameter int TASK_DEPTH = u2f_pkg::TASK_DEPTH,
  parameter int OUT_DEPTH  = u2f_pkg::OUT_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       full,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_error
);
  import u2f_pkg::*;

  logic  job_push;
  logic  job_full;
  logic  job_pop;
  logic  job_empty;
  job_t  job_in;
  job_t  job_out;
  logic  hand_valid;
  logic  hand_pop;
  hand_t hand_data;
  logic  res_push;
  logic  res_full;
  res_t  res_in;
  res_t  res_out;

  assign full = job_full;

  u2f_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .job_full (job_full),
    .job_push (job_push),
    .job_data (job_in)
  );

  u2f_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (TASK_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  u2f_zeck u_zeck (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (!job_empty),
    .job_data   (job_out),
    .job_pop    (job_pop),
    .hand_valid (hand_valid),
    .hand_data  (hand_data),
    .hand_pop   (hand_pop)
  );

  u2f_pack u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .hand_valid (hand_valid),
    .hand_data  (hand_data),
    .hand_pop   (hand_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_data   (res_in)
  );

  u2f_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign out_byte  = res_out.data;
  assign out_last  = res_out.last;
  assign out_error = res_out.err;

  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("packer wrote a result into a full queue");

  a_hand_hold: assert property (@(posedge clk) disable iff (!rst_n)
    hand_valid && !hand_pop |=> hand_valid)
    else $error("codeword dropped before the packer took it");

  a_job_pop: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> !job_empty)
    else $error("search took a job from an empty queue");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

endmodule

// ===== rtl/core/u2f_fifo.sv =====
// u2f_fifo: small register-based first-in first-out queue
// no package dependencies
module u2f_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/u2f_front.sv =====
// u2f_front: utf-8 sequence decoder, classifies each byte and queues one job
// per finished code point or error; depends on u2f_pkg
module u2f_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  logic          job_full,
  output logic          job_push,
  output u2f_pkg::job_t job_data
);
  import u2f_pkg::*;

  logic [CP_W-1:0] acc_r, acc_nxt;
  logic [1:0]      need_r, need_nxt;
  logic [1:0]      cls_r, cls_nxt;
  logic            failed_r, failed_nxt;
  logic            take;
  logic            err;
  logic            done;

  assign take = push && !job_full;

  always_comb begin
    acc_nxt    = acc_r;
    need_nxt   = need_r;
    cls_nxt    = cls_r;
    failed_nxt = failed_r;
    err        = 1'b0;
    done       = 1'b0;
    job_push   = 1'b0;
    job_data   = '0;
    if (take) begin
      if (failed_r) begin
        // drop bytes until the end of the stream
        if (in_last) begin
          failed_nxt = 1'b0;
          need_nxt   = '0;
        end
      end else begin
        if (need_r == 2'd0) begin
          unique case (in_byte) inside
            [ASCII_LO:ASCII_HI]: begin
              acc_nxt = CP_W'(in_byte);
              cls_nxt = CLS_1B;
              done    = 1'b1;
            end
            [CONT_LO:CONT_HI]: begin
              err = 1'b1;
            end
            [LEAD2_LO:LEAD2_HI]: begin
              acc_nxt  = CP_W'(in_byte[4:0]);
              need_nxt = 2'd1;
              cls_nxt  = CLS_2B;
            end
            [LEAD3_LO:LEAD3_HI]: begin
              acc_nxt  = CP_W'(in_byte[3:0]);
              need_nxt = 2'd2;
              cls_nxt  = CLS_3B;
            end
            [LEAD4_LO:LEAD4_HI]: begin
              acc_nxt  = CP_W'(in_byte[2:0]);
              need_nxt = 2'd3;
              cls_nxt  = CLS_4B;
            end
            default: begin
              err = 1'b1;
            end
          endcase
        end else if (in_byte[7:6] == CONT_TAG) begin
          acc_nxt  = {acc_r[CP_W-7:0], in_byte[5:0]};
          need_nxt = need_r - 2'd1;
          done     = (need_r == 2'd1);
        end else begin
          err = 1'b1;
        end
        if (!err && done && (acc_nxt > CP_MAX)) err = 1'b1;
        if (!err && in_last && (need_nxt != 2'd0)) err = 1'b1;
        job_push      = err || done;
        job_data.err  = err;
        job_data.last = in_last;
        job_data.cls  = cls_nxt;
        job_data.cp   = acc_nxt;
        if (err) begin
          need_nxt   = '0;
          failed_nxt = !in_last;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    cls_r <= cls_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r   <= '0;
      failed_r <= 1'b0;
    end else begin
      need_r   <= need_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

// ===== rtl/core/u2f_zeck.sv =====
// u2f_zeck: greedy zeckendorf search, ZSTEPS terms per cycle from the top term
// a sequence length allows; holds the finished codeword; depends on u2f_pkg
module u2f_zeck (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  input  u2f_pkg::job_t  job_data,
  output logic           job_pop,
  output logic           hand_valid,
  output u2f_pkg::hand_t hand_data,
  input  logic           hand_pop
);
  import u2f_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [VW-1:0]        v_r, v_nxt;
  idx_t                 idx_r, idx_nxt;
  logic [FIB_TERMS-1:0] sel_r, sel_nxt;
  logic [IDX_W-1:0]     top_r, top_nxt;
  logic                 topv_r, topv_nxt;
  logic                 last_r, last_nxt;
  logic                 err_r, err_nxt;
  logic                 hand_v_r, hand_v_nxt;
  hand_t                hand_r, hand_nxt;

  logic                 hand_free;
  logic                 finish;
  logic [VW-1:0]        v;
  idx_t                 i;
  logic [FIB_TERMS-1:0] sel;
  logic [IDX_W-1:0]     top;
  logic                 topv;
  logic [VW-1:0]        f;

  assign hand_valid = hand_v_r;
  assign hand_data  = hand_r;

  always_comb begin
    busy_nxt   = busy_r;
    v_nxt      = v_r;
    idx_nxt    = idx_r;
    sel_nxt    = sel_r;
    top_nxt    = top_r;
    topv_nxt   = topv_r;
    last_nxt   = last_r;
    err_nxt    = err_r;
    hand_v_nxt = hand_v_r;
    hand_nxt   = hand_r;

    hand_free = !hand_v_r || hand_pop;
    finish    = busy_r && idx_r[IDX_W] && hand_free;

    v    = v_r;
    i    = idx_r;
    sel  = sel_r;
    top  = top_r;
    topv = topv_r;
    f    = '0;
    for (int s = 0; s < ZSTEPS; s++) begin
      if (!i[IDX_W]) begin
        f = VW'(FIB_TAB[i[IDX_W-1:0]]);
        if (f <= v) begin
          v                  = v - f;
          sel[i[IDX_W-1:0]] = 1'b1;
          if (!topv) begin
            top  = i[IDX_W-1:0];
            topv = 1'b1;
          end
          i = i - idx_t'(2);
        end else begin
          i = i - idx_t'(1);
        end
      end
    end

    if (busy_r && !idx_r[IDX_W]) begin
      v_nxt    = v;
      idx_nxt  = i;
      sel_nxt  = sel;
      top_nxt  = top;
      topv_nxt = topv;
    end

    if (hand_pop) hand_v_nxt = 1'b0;

    if (finish) begin
      hand_v_nxt    = 1'b1;
      hand_nxt.err  = err_r;
      hand_nxt.last = last_r;
      hand_nxt.code = err_r ? '0 : (CODE_W'(sel_r) | (CODE_W'(1) << (top_r + 1)));
      hand_nxt.len  = err_r ? '0 : LEN_W'(top_r) + LEN_W'(2);
      busy_nxt      = 1'b0;
    end

    job_pop = job_valid && (!busy_r || finish);
    if (job_pop) begin
      busy_nxt = 1'b1;
      last_nxt = job_data.last;
      err_nxt  = job_data.err;
      v_nxt    = VW'(job_data.cp) + VW'(1);
      idx_nxt  = job_data.err ? '1 : start_idx(job_data.cls);
      sel_nxt  = '0;
      topv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    idx_r  <= idx_nxt;
    sel_r  <= sel_nxt;
    top_r  <= top_nxt;
    topv_r <= topv_nxt;
    last_r <= last_nxt;
    err_r  <= err_nxt;
    hand_r <= hand_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      hand_v_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      hand_v_r <= hand_v_nxt;
    end
  end

endmodule

// ===== rtl/core/u2f_pack.sv =====
// u2f_pack: packs codewords lsb first into bytes, up to eight bits a cycle unless
// a full byte stalls, and emits error and end-of-stream results; depends on u2f_pkg
module u2f_pack (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           hand_valid,
  input  u2f_pkg::hand_t hand_data,
  output logic           hand_pop,
  input  logic           res_full,
  output logic           res_push,
  output u2f_pkg::res_t  res_data
);
  import u2f_pkg::*;

  logic              act_r, act_nxt;
  logic              err_r, err_nxt;
  logic              last_r, last_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [7:0]        pbits_r, pbits_nxt;
  logic [3:0]        pcnt_r, pcnt_nxt;

  logic              full_byte;
  logic [7:0]        base_bits;
  logic [3:0]        base_cnt;
  logic [3:0]        room;
  logic [3:0]        n;
  logic [7:0]        chunk;

  always_comb begin
    act_nxt   = act_r;
    err_nxt   = err_r;
    last_nxt  = last_r;
    code_nxt  = code_r;
    rem_nxt   = rem_r;
    pbits_nxt = pbits_r;
    pcnt_nxt  = pcnt_r;
    res_push  = 1'b0;
    res_data  = '0;

    // a full byte is held until the next bit or the end of the stream, or dropped on an error
    full_byte = (pcnt_r == 4'd8);
    base_bits = full_byte ? 8'h00 : pbits_r;
    base_cnt  = full_byte ? 4'd0 : pcnt_r;
    room      = 4'd8 - base_cnt;
    n         = (rem_r < LEN_W'(room)) ? 4'(rem_r) : room;
    chunk     = code_r[7:0] & (8'hFF >> (4'd8 - n));

    if (act_r) begin
      if (err_r) begin
        if (!res_full) begin
          res_push      = 1'b1;
          res_data.data = 8'h00;
          res_data.last = last_r;
          res_data.err  = 1'b1;
          pbits_nxt     = '0;
          pcnt_nxt      = '0;
          act_nxt       = 1'b0;
        end
      end else if (rem_r != '0) begin
        if (!full_byte || !res_full) begin
          if (full_byte) begin
            res_push      = 1'b1;
            res_data.data = pbits_r;
            res_data.last = 1'b0;
            res_data.err  = 1'b0;
          end
          pbits_nxt = base_bits | 8'(chunk << base_cnt);
          pcnt_nxt  = base_cnt + n;
          code_nxt  = code_r >> n;
          rem_nxt   = rem_r - LEN_W'(n);
          if ((rem_nxt == '0) && !last_r) act_nxt = 1'b0;
        end
      end else begin
        if (!res_full) begin
          res_push      = 1'b1;
          res_data.data = pbits_r;
          res_data.last = 1'b1;
          res_data.err  = 1'b0;
          pbits_nxt     = '0;
          pcnt_nxt      = '0;
          act_nxt       = 1'b0;
        end
      end
    end

    hand_pop = hand_valid && !act_nxt;
    if (hand_pop) begin
      act_nxt  = 1'b1;
      err_nxt  = hand_data.err;
      last_nxt = hand_data.last;
      code_nxt = hand_data.code;
      rem_nxt  = hand_data.len;
    end
  end

  always_ff @(posedge clk) begin
    err_r  <= err_nxt;
    last_r <= last_nxt;
    code_r <= code_nxt;
    rem_r  <= rem_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= 1'b0;
      pbits_r <= '0;
      pcnt_r  <= '0;
    end else begin
      act_r   <= act_nxt;
      pbits_r <= pbits_nxt;
      pcnt_r  <= pcnt_nxt;
    end
  end

endmodule

// ===== tb/utf8_to_fibonacci_transcoder_top_tb.sv =====
// utf8_to_fibonacci_transcoder_top_tb: self-checking bench for the utf-8 to fibonacci-code
// transcoder; a scoreboard class predicts every packed byte, tasks drive both queues
// depends on u2f_pkg and utf8_to_fibonacci_transcoder_top
module utf8_to_fibonacci_transcoder_top_tb;
  import u2f_pkg::*;

  class u2f_transcode_board;
    int unsigned fib_term [FIB_TERMS];
    logic [CP_W-1:0] cp_acc;
    logic [1:0] need;
    logic [7:0] acc_bits;
    int unsigned acc_cnt;
    bit failed;
    res_t due_q [$];
    int errors;
    int checked;
    int flagged;

    function new();
      fib_term[0] = 1;
      fib_term[1] = 2;
      for (int i = 2; i < FIB_TERMS; i++) fib_term[i] = fib_term[i-1] + fib_term[i-2];
      clear_stream();
      errors = 0;
      checked = 0;
      flagged = 0;
    endfunction

    function void clear_stream();
      cp_acc = '0;
      need = '0;
      acc_bits = '0;
      acc_cnt = 0;
      failed = 1'b0;
    endfunction

    function void add_result(logic [7:0] d, logic l, logic e);
      res_t r;
      r.data = d;
      r.last = l;
      r.err = e;
      due_q.push_back(r);
    endfunction

    function void put_bit(bit v);
      if (acc_cnt >= 8) begin
        add_result(acc_bits, 1'b0, 1'b0);
        acc_bits = '0;
        acc_cnt = 0;
      end
      acc_bits[acc_cnt] = v;
      acc_cnt++;
    endfunction

    // greedy zeckendorf split of cp+1, lowest term first, closing 1
    function void put_code(logic [CP_W-1:0] cp);
      int unsigned v;
      bit [31:0] sel;
      int top;
      int i;
      v = int'(cp) + 1;
      sel = '0;
      top = -1;
      i = FIB_TERMS - 1;
      while (i >= 0) begin
        if (fib_term[i] <= v) begin
          v -= fib_term[i];
          sel[i] = 1'b1;
          if (top < 0) top = i;
          i -= 2;
        end else begin
          i--;
        end
      end
      for (i = 0; i <= top; i++) put_bit(sel[i]);
      put_bit(1'b1);
    endfunction

    function void note_request(logic [7:0] b, logic last);
      bit bad;
      bit done;
      bad = 1'b0;
      done = 1'b0;
      if (failed) begin
        if (last) clear_stream();
        return;
      end
      if (need == 0) begin
        if (b <= ASCII_HI) begin
          cp_acc = CP_W'(b);
          done = 1'b1;
        end else if (b <= CONT_HI) begin
          bad = 1'b1;
        end else if (b <= LEAD2_HI) begin
          cp_acc = CP_W'(8'(b - LEAD2_LO));
          need = 2'd1;
        end else if (b <= LEAD3_HI) begin
          cp_acc = CP_W'(8'(b - LEAD3_LO));
          need = 2'd2;
        end else if (b <= LEAD4_HI) begin
          cp_acc = CP_W'(8'(b - LEAD4_LO));
          need = 2'd3;
        end else begin
          bad = 1'b1;
        end
      end else if (b[7:6] == CONT_TAG) begin
        cp_acc = {cp_acc[CP_W-7:0], b[5:0]};
        need--;
        if (need == 0) done = 1'b1;
      end else begin
        bad = 1'b1;
      end
      if (!bad && done && cp_acc > CP_MAX) bad = 1'b1;
      if (!bad && last && need != 0) bad = 1'b1;
      if (bad) begin
        add_result(8'h00, last, 1'b1);
        clear_stream();
        failed = !last;
        return;
      end
      if (done) put_code(cp_acc);
      if (last) begin
        if (acc_cnt > 0) add_result(acc_bits, 1'b1, 1'b0);
        clear_stream();
      end
    endfunction

    function void check_result(logic [7:0] d, logic l, logic e);
      res_t w;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual byte %02h last %0b error %0b",
                 $time, d, l, e);
        return;
      end
      w = due_q.pop_front();
      checked++;
      if (w.err) flagged++;
      if (w.data !== d) begin
        errors++;
        $display("%0t: out_byte expected %02h actual %02h", $time, w.data, d);
      end
      if (w.last !== l) begin
        errors++;
        $display("%0t: out_last expected %0b actual %0b", $time, w.last, l);
      end
      if (w.err !== e) begin
        errors++;
        $display("%0t: out_error expected %0b actual %0b", $time, w.err, e);
      end
    endfunction

    function int outstanding();
      return due_q.size();
    endfunction
  endclass

  localparam int ITEMS       = 480;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN       = 60;

  typedef struct packed {
    logic [7:0] b;
    logic       l;
  } byte_req_t;

  typedef enum int {F_STRAY, F_BAD_LEAD, F_MISSING, F_TRUNC, F_TOO_BIG, F_NOISE} fault_e;

  logic       clk;
  logic       rst_n   = 1'b0;
  logic       push    = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       pop     = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_error;

  u2f_transcode_board sb = new();
  byte_req_t stim_q [$];
  int total;
  int streams;
  int hold_at;
  int idx = 0;
  int accepted = 0;
  int hold_left = 0;
  bit held = 1'b0;
  int quiet = 0;

  utf8_to_fibonacci_transcoder_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_last (out_last),
    .out_error(out_error)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int send_idle_pct(int n);
    if (n < total / 3) return 6;
    if (n < 2 * total / 3) return 74;
    return 0;
  endfunction

  function automatic int recv_idle_pct(int n);
    if (n < total / 3) return 74;
    if (n < 2 * total / 3) return 6;
    return 0;
  endfunction

  task automatic put_byte(logic [7:0] b, logic l);
    byte_req_t r;
    r.b = b;
    r.l = l;
    stim_q.push_back(r);
    if (l) streams++;
  endtask

  function automatic logic [7:0] rand_cont();
    return CONT_LO | 8'($urandom_range(0, 63));
  endfunction

  function automatic logic [7:0] rand_lead(int len);
    if (len == 2) return LEAD2_LO | 8'($urandom_range(0, 31));
    if (len == 3) return LEAD3_LO | 8'($urandom_range(0, 15));
    return LEAD4_LO | 8'($urandom_range(0, 7));
  endfunction

  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 1;
    if (r < 6) return 2;
    if (r < 8) return 3;
    return 4;
  endfunction

  function automatic logic [CP_W-1:0] rand_cp(int len);
    if (len == 1) return CP_W'($urandom_range(0, 127));
    if (len == 2) return CP_W'($urandom_range(0, 2047));
    if (len == 3) return CP_W'($urandom_range(0, 65535));
    if ($urandom_range(0, 7) == 0) return CP_MAX;
    return CP_W'($urandom_range(0, int'(CP_MAX)));
  endfunction

  task automatic put_char(logic [CP_W-1:0] cp, int len, logic l);
    case (len)
      1: put_byte(8'(cp[6:0]), l);
      2: begin
        put_byte(LEAD2_LO | 8'(cp[10:6]), 1'b0);
        put_byte(CONT_LO | 8'(cp[5:0]), l);
      end
      3: begin
        put_byte(LEAD3_LO | 8'(cp[15:12]), 1'b0);
        put_byte(CONT_LO | 8'(cp[11:6]), 1'b0);
        put_byte(CONT_LO | 8'(cp[5:0]), l);
      end
      default: begin
        put_byte(LEAD4_LO | 8'(cp[20:18]), 1'b0);
        put_byte(CONT_LO | 8'(cp[17:12]), 1'b0);
        put_byte(CONT_LO | 8'(cp[11:6]), 1'b0);
        put_byte(CONT_LO | 8'(cp[5:0]), l);
      end
    endcase
  endtask

  task automatic put_stream(bit faulty);
    int nch;
    int len;
    int pos;
    int trail;
    fault_e f;
    logic [7:0] x;
    nch = $urandom_range(1, 6);
    if (!faulty) begin
      for (int k = 0; k < nch; k++) begin
        len = rand_len();
        put_char(rand_cp(len), len, k == nch - 1);
      end
      return;
    end
    f = fault_e'($urandom_range(0, 5));
    pos = $urandom_range(0, nch - 1);
    for (int k = 0; k < pos; k++) begin
      len = rand_len();
      put_char(rand_cp(len), len, 1'b0);
    end
    case (f)
      F_STRAY: put_byte(rand_cont(), 1'b0);
      F_BAD_LEAD: put_byte(8'($urandom_range(int'(LEAD4_HI) + 1, 255)), 1'b0);
      F_MISSING, F_TRUNC: begin
        len = $urandom_range(2, 4);
        put_byte(rand_lead(len), 1'b0);
        for (int k = $urandom_range(0, len - 2); k > 0; k--) put_byte(rand_cont(), 1'b0);
        if (f == F_TRUNC) begin
          stim_q[stim_q.size()-1].l = 1'b1;
          streams++;
          return;
        end
        x = 8'($urandom);
        while (x[7:6] == CONT_TAG) x = 8'($urandom);
        put_byte(x, 1'b0);
      end
      F_TOO_BIG: put_char(CP_W'($urandom_range(int'(CP_MAX) + 1, 21'h1FFFFF)), 4, 1'b0);
      default: for (int k = $urandom_range(1, 6); k > 0; k--) put_byte(8'($urandom), 1'b0);
    endcase
    trail = $urandom_range(0, 3);
    if (trail == 0) begin
      stim_q[stim_q.size()-1].l = 1'b1;
      streams++;
    end else begin
      for (int k = 0; k < trail; k++) put_byte(8'($urandom), k == trail - 1);
    end
  endtask

  task automatic build_stimulus();
    // extremes of the one- to three-byte lengths, ending on the largest code point
    put_byte(8'h00, 1'b0);
    put_byte(ASCII_HI, 1'b0);
    put_char(CP_W'(8'h80), 2, 1'b0);
    put_char(CP_W'(11'h7FF), 2, 1'b0);
    put_char(CP_W'(0), 3, 1'b0);
    put_char(CP_W'(16'hFFFF), 3, 1'b0);
    put_char(CP_MAX, 4, 1'b1);
    // stray continuation, then ignored bytes up to last
    put_byte(CONT_LO, 1'b0);
    put_byte(8'h41, 1'b1);
    // bad lead on the last byte
    put_byte(8'hFF, 1'b1);
    // missing continuation
    put_byte(8'hC3, 1'b0);
    put_byte(8'h41, 1'b1);
    // truncated sequence
    put_byte(8'hE2, 1'b0);
    put_byte(8'h82, 1'b1);
    // code point above the unicode range
    put_char(CP_W'(CP_MAX + 1), 4, 1'b1);
    while (stim_q.size() < ITEMS) put_stream($urandom_range(0, 99) < 22);
  endtask

  task automatic send_step();
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        sb.note_request(in_byte, in_last);
        accepted <= accepted + 1;
      end
      if (!push || !full) begin
        if (idx < total && $urandom_range(0, 99) >= send_idle_pct(idx)) begin
          push    <= 1'b1;
          in_byte <= stim_q[idx].b;
          in_last <= stim_q[idx].l;
          idx     <= idx + 1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  endtask

  task automatic recv_step();
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) sb.check_result(out_byte, out_last, out_error);
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else if (!held && idx >= hold_at) begin
        // long receiver stall so the block backs up to full
        hold_left <= HOLD_CYCLES;
        held <= 1'b1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct(idx));
      end
    end
  endtask

  always @(posedge clk) send_step();
  always @(posedge clk) recv_step();

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, quiet);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    streams = 0;
    build_stimulus();
    total = stim_q.size();
    hold_at = total * 5 / 6;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (accepted < total) @(negedge clk);
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    $display("covered %0d input bytes in %0d streams under three idle mixes and a full stall",
             total, streams);
    $display("checked %0d packed results, %0d of them error results", sb.checked, sb.flagged);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
